// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the tar stream deframer modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define TSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds.
`define TSD_ASSERT_NEVER(label, cond, msg) \
    `TSD_ASSERT(label, !(cond), msg)

`endif

// File: sv/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants of the tar stream deframer.
// ----------------------------------------------------------------------------
package tsd_pkg;

    localparam logic [2:0] KIND_DATA    = 3'd0;
    localparam logic [2:0] KIND_FILE    = 3'd1;
    localparam logic [2:0] KIND_DIR     = 3'd2;
    localparam logic [2:0] KIND_END     = 3'd3;
    localparam logic [2:0] KIND_BAD_SUM = 3'd4;
    localparam logic [2:0] KIND_CORRUPT = 3'd5;

    localparam logic [8:0] BLOCK_LAST   = 9'd511;
    localparam logic [8:0] MODE_FIRST   = 9'd100;
    localparam logic [8:0] MODE_END     = 9'd107;
    localparam logic [8:0] SIZE_FIRST   = 9'd124;
    localparam logic [8:0] SIZE_END     = 9'd135;
    localparam logic [8:0] CHK_FIRST    = 9'd148;
    localparam logic [8:0] CHK_DIG_END  = 9'd154;
    localparam logic [8:0] CHK_END      = 9'd156;
    localparam logic [8:0] TYPE_POS     = 9'd156;
    localparam logic [8:0] PREFIX_POS   = 9'd345;

    localparam logic [7:0] ASCII_ZERO   = 8'd48;
    localparam logic [7:0] ASCII_SPACE  = 8'd32;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic        last_data;
        logic [31:0] file_size;
        logic [20:0] file_mode;
        logic        has_prefix;
    } item_t;

endpackage

// File: sv/tsd_front.sv
// ----------------------------------------------------------------------------
// tsd_front
// Block framing and header parsing; emits one queue entry per result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          byte_in,
    output logic                q_push,
    output tsd_pkg::item_t      q_item
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ZERO,
        PH_PAYLOAD,
        PH_PAD,
        PH_HALT
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [8:0]     byte_pos_reg, byte_pos_next;
    logic [16:0]    header_sum_reg, header_sum_next;
    logic [31:0]    checksum_reg, checksum_next;
    logic [31:0]    size_acc_reg, size_acc_next;
    logic [20:0]    mode_acc_reg, mode_acc_next;
    logic           regular_reg, regular_next;
    logic           prefix_reg, prefix_next;
    logic           all_zero_reg, all_zero_next;
    logic [31:0]    payload_left_reg, payload_left_next;
    logic [8:0]     pad_left_reg, pad_left_next;
    logic           q_push_reg, q_push_next;
    tsd_pkg::item_t q_item_reg, q_item_next;

    logic           clear;
    logic           in_chk_span;
    logic [31:0]    digit32;
    logic [20:0]    digit21;

    assign in_chk_span = (byte_pos_reg >= tsd_pkg::CHK_FIRST) &&
                         (byte_pos_reg < tsd_pkg::CHK_END);
    assign digit32 = {24'd0, byte_in} - {24'd0, tsd_pkg::ASCII_ZERO};
    assign digit21 = digit32[20:0];

    always_comb
    begin
        phase_next        = phase_reg;
        byte_pos_next     = byte_pos_reg;
        header_sum_next   = header_sum_reg;
        checksum_next     = checksum_reg;
        size_acc_next     = size_acc_reg;
        mode_acc_next     = mode_acc_reg;
        regular_next      = regular_reg;
        prefix_next       = prefix_reg;
        all_zero_next     = all_zero_reg;
        payload_left_next = payload_left_reg;
        pad_left_next     = pad_left_reg;
        q_push_next       = 1'b0;
        q_item_next       = '0;
        clear             = 1'b0;

        if (in_valid)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    header_sum_next = header_sum_reg +
                        {9'd0, (in_chk_span ? tsd_pkg::ASCII_SPACE : byte_in)};
                    if (byte_in != 8'd0)
                        all_zero_next = 1'b0;
                    if (byte_pos_reg >= tsd_pkg::CHK_FIRST &&
                        byte_pos_reg < tsd_pkg::CHK_DIG_END)
                        checksum_next = {checksum_reg[28:0], 3'b000} + digit32;
                    if (byte_pos_reg >= tsd_pkg::SIZE_FIRST &&
                        byte_pos_reg < tsd_pkg::SIZE_END)
                        size_acc_next = {size_acc_reg[28:0], 3'b000} + digit32;
                    if (byte_pos_reg >= tsd_pkg::MODE_FIRST &&
                        byte_pos_reg < tsd_pkg::MODE_END)
                        mode_acc_next = {mode_acc_reg[17:0], 3'b000} + digit21;
                    if (byte_pos_reg == tsd_pkg::TYPE_POS)
                        regular_next = (byte_in == tsd_pkg::ASCII_ZERO) ||
                                       (byte_in == 8'd0);
                    if (byte_pos_reg == tsd_pkg::PREFIX_POS)
                        prefix_next = (byte_in != 8'd0);

                    if (byte_pos_reg != tsd_pkg::BLOCK_LAST)
                    begin
                        byte_pos_next = byte_pos_reg + 9'd1;
                    end
                    else if (all_zero_next)
                    begin
                        phase_next = PH_ZERO;
                        clear      = 1'b1;
                    end
                    else if (checksum_reg != {15'd0, header_sum_next})
                    begin
                        q_push_next      = 1'b1;
                        q_item_next.kind = tsd_pkg::KIND_BAD_SUM;
                        phase_next       = PH_HALT;
                    end
                    else
                    begin
                        q_push_next            = 1'b1;
                        q_item_next.file_size  = size_acc_reg;
                        q_item_next.file_mode  = mode_acc_reg;
                        q_item_next.has_prefix = prefix_reg;
                        clear                  = 1'b1;
                        phase_next             = PH_HEADER;
                        if (regular_reg)
                        begin
                            q_item_next.kind = tsd_pkg::KIND_FILE;
                            if (size_acc_reg != 32'd0)
                            begin
                                payload_left_next = size_acc_reg;
                                pad_left_next     = 9'd0 - size_acc_reg[8:0];
                                phase_next        = PH_PAYLOAD;
                            end
                        end
                        else
                        begin
                            q_item_next.kind = tsd_pkg::KIND_DIR;
                        end
                    end
                end
                PH_ZERO:
                begin
                    if (byte_in != 8'd0)
                        all_zero_next = 1'b0;
                    if (byte_pos_reg != tsd_pkg::BLOCK_LAST)
                    begin
                        byte_pos_next = byte_pos_reg + 9'd1;
                    end
                    else
                    begin
                        q_push_next      = 1'b1;
                        q_item_next.kind = all_zero_next ? tsd_pkg::KIND_END
                                                         : tsd_pkg::KIND_CORRUPT;
                        phase_next       = PH_HALT;
                    end
                end
                PH_PAYLOAD:
                begin
                    q_push_next           = 1'b1;
                    q_item_next.kind      = tsd_pkg::KIND_DATA;
                    q_item_next.data_byte = byte_in;
                    q_item_next.last_data = (payload_left_reg == 32'd1);
                    payload_left_next     = payload_left_reg - 32'd1;
                    if (payload_left_reg == 32'd1)
                    begin
                        phase_next = (pad_left_reg != 9'd0) ? PH_PAD : PH_HEADER;
                        clear      = 1'b1;
                    end
                end
                PH_PAD:
                begin
                    pad_left_next = pad_left_reg - 9'd1;
                    if (pad_left_reg == 9'd1)
                    begin
                        phase_next = PH_HEADER;
                        clear      = 1'b1;
                    end
                end
                PH_HALT:
                begin
                    phase_next = PH_HALT;
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase

            if (clear)
            begin
                byte_pos_next   = 9'd0;
                header_sum_next = 17'd0;
                checksum_next   = 32'd0;
                size_acc_next   = 32'd0;
                mode_acc_next   = 21'd0;
                regular_next    = 1'b0;
                prefix_next     = 1'b0;
                all_zero_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            byte_pos_reg     <= 9'd0;
            header_sum_reg   <= 17'd0;
            checksum_reg     <= 32'd0;
            size_acc_reg     <= 32'd0;
            mode_acc_reg     <= 21'd0;
            regular_reg      <= 1'b0;
            prefix_reg       <= 1'b0;
            all_zero_reg     <= 1'b1;
            payload_left_reg <= 32'd0;
            pad_left_reg     <= 9'd0;
            q_push_reg       <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            byte_pos_reg     <= byte_pos_next;
            header_sum_reg   <= header_sum_next;
            checksum_reg     <= checksum_next;
            size_acc_reg     <= size_acc_next;
            mode_acc_reg     <= mode_acc_next;
            regular_reg      <= regular_next;
            prefix_reg       <= prefix_next;
            all_zero_reg     <= all_zero_next;
            payload_left_reg <= payload_left_next;
            pad_left_reg     <= pad_left_next;
            q_push_reg       <= q_push_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_item_reg <= q_item_next;
    end

    assign q_push = q_push_reg;
    assign q_item = q_item_reg;

    `TSD_ASSERT(a_payload_nonzero,
        (phase_reg == PH_PAYLOAD) |-> (payload_left_reg != 32'd0),
        "payload phase with no bytes left")
    `TSD_ASSERT(a_halt_silent,
        (phase_reg == PH_HALT) |=> !q_push_reg,
        "entry emitted after halt")
    `TSD_ASSERT(a_halt_sticky,
        (phase_reg == PH_HALT) |=> (phase_reg == PH_HALT),
        "left halt without reset")

endmodule

// File: sv/tsd_queue.sv
// ----------------------------------------------------------------------------
// tsd_queue
// Short queue between the parsing front and the result back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsd_queue
#(
    parameter int DEPTH = tsd_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  tsd_pkg::item_t wr_item,
    output logic           full,
    output logic           almost_full,
    input  logic           rd_en,
    output tsd_pkg::item_t rd_item,
    output logic           empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_AFULL = CNT_W'(DEPTH - 1);

    tsd_pkg::item_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full        = (count_reg == CNT_FULL);
    assign almost_full = (count_reg >= CNT_AFULL);
    assign empty       = (count_reg == '0);
    assign do_wr       = wr_en && !full;
    assign do_rd       = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

    assign rd_item = slot_reg[rd_ptr_reg];

    `TSD_ASSERT(a_count_bound,
        count_reg <= CNT_FULL,
        "queue count beyond depth")
    `TSD_ASSERT_NEVER(a_no_overflow,
        wr_en && full,
        "write into full queue")

endmodule

// File: sv/tsd_back.sv
// ----------------------------------------------------------------------------
// tsd_back
// Result stage: moves queue entries into the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsd_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  tsd_pkg::item_t q_item,
    output logic           q_pop,
    output logic           empty,
    input  logic           pop,
    output logic [2:0]     kind,
    output logic [7:0]     data_byte,
    output logic           last_data,
    output logic [31:0]    file_size,
    output logic [20:0]    file_mode,
    output logic           has_prefix
);

    logic           out_valid_reg, out_valid_next;
    tsd_pkg::item_t out_item_reg;
    logic           load;

    assign load           = !q_empty && (!out_valid_reg || pop);
    assign out_valid_next = load || (out_valid_reg && !pop);
    assign q_pop          = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_item_reg <= q_item;
    end

    assign empty      = !out_valid_reg;
    assign kind       = out_item_reg.kind;
    assign data_byte  = out_item_reg.data_byte;
    assign last_data  = out_item_reg.last_data;
    assign file_size  = out_item_reg.file_size;
    assign file_mode  = out_item_reg.file_mode;
    assign has_prefix = out_item_reg.has_prefix;

    `TSD_ASSERT(a_refill,
        (!q_empty && !out_valid_reg) |=> out_valid_reg,
        "waiting entry not moved to output")

endmodule

// File: sv/tar_stream_deframer.sv
// ----------------------------------------------------------------------------
// tar_stream_deframer
// Tar archive byte stream parser: header results and file payload bytes.
// ----------------------------------------------------------------------------
// Takes one archive byte per cycle, every cycle, as long as full is low; full
// rises only when the result queue (QUEUE_DEPTH entries, set by the queue
// between the header parser and the output register) has no free slot left
// once the entry still on its way from the parser is counted, which happens
// only while pop is held low. A result is registered in the parser, written
// into the queue, then loaded into the output register. Each header is
// checked at its last byte; a file's payload bytes come out with last_data on
// the final one and its padding is dropped. After an end, bad checksum or
// corrupt result every byte is taken and ignored until reset.
// ----------------------------------------------------------------------------
module tar_stream_deframer
#(
    parameter int QUEUE_DEPTH = tsd_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  byte_in,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  kind,
    output logic [7:0]  data_byte,
    output logic        last_data,
    output logic [31:0] file_size,
    output logic [20:0] file_mode,
    output logic        has_prefix
);

    logic           in_valid;
    logic           q_push;
    logic           q_full;
    logic           q_almost_full;
    logic           q_empty;
    logic           q_pop;
    tsd_pkg::item_t q_wr_item;
    tsd_pkg::item_t q_rd_item;

    assign full     = q_full || (q_almost_full && q_push);
    assign in_valid = push && !full;

    tsd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .byte_in  (byte_in),
        .q_push   (q_push),
        .q_item   (q_wr_item)
    );

    tsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (q_push),
        .wr_item     (q_wr_item),
        .full        (q_full),
        .almost_full (q_almost_full),
        .rd_en       (q_pop),
        .rd_item     (q_rd_item),
        .empty       (q_empty)
    );

    tsd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_item     (q_rd_item),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .kind       (kind),
        .data_byte  (data_byte),
        .last_data  (last_data),
        .file_size  (file_size),
        .file_mode  (file_mode),
        .has_prefix (has_prefix)
    );

endmodule
